// ----- hdl/cpsp_pkg.sv -----
// Shared types and constants of the cascaded position/speed PID block.
`default_nettype none

package cpsp_pkg;

    // Number formats
    localparam int FRACTION_BITS = 12;
    localparam int GAIN_FRAC     = 12;
    localparam int INTEGRAL_BITS = 40;
    localparam int GAIN_W        = 16;
    localparam int ERR_W         = 32;
    localparam int PERIOD_W      = 8;
    localparam int DELTA_W       = 8;
    localparam int COUNT_W       = 16;
    localparam int MOTOR_W       = 8;
    localparam int SPEED_TGT_W   = 18;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 16;

    // Derived widths
    localparam int SUM_FRAC   = FRACTION_BITS + GAIN_FRAC;
    localparam int HELD_W     = FRACTION_BITS + 6;
    localparam int ERR_WIDE_W = (FRACTION_BITS + 18 > ERR_W + 1) ? FRACTION_BITS + 18
                                                                  : ERR_W + 1;
    localparam int LIM_W      = SUM_FRAC + 8;
    localparam int PROD_P_W   = GAIN_W + 1 + ERR_W;
    localparam int PROD_D_W   = GAIN_W + 2 + ERR_W;
    localparam int PROD_I_W   = GAIN_W + 1 + INTEGRAL_BITS;
    localparam int TERM_SHIFT = 62;
    localparam int ITERM_W    = (PROD_I_W > TERM_SHIFT + 1) ? TERM_SHIFT + 2 : PROD_I_W;
    localparam int PID_SUM_W  = ((ITERM_W > PROD_D_W) ? ITERM_W : PROD_D_W) + 2;

    // Output limits
    localparam int DRIVE_LIMIT  = 100;
    localparam int TARGET_LIMIT = 20;
    localparam logic signed [LIM_W-1:0] INNER_LIMIT = LIM_W'(DRIVE_LIMIT) << SUM_FRAC;
    localparam logic signed [LIM_W-1:0] OUTER_LIMIT = LIM_W'(TARGET_LIMIT) << SUM_FRAC;

    // Register reset values
    localparam logic [GAIN_W-1:0]   INNER_KP_RESET  = GAIN_W'(1229);
    localparam logic [GAIN_W-1:0]   INNER_KI_RESET  = GAIN_W'(1229);
    localparam logic [GAIN_W-1:0]   INNER_KD_RESET  = GAIN_W'(0);
    localparam logic [GAIN_W-1:0]   OUTER_KP_RESET  = GAIN_W'(1229);
    localparam logic [GAIN_W-1:0]   OUTER_KI_RESET  = GAIN_W'(0);
    localparam logic [GAIN_W-1:0]   OUTER_KD_RESET  = GAIN_W'(1638);
    localparam logic [PERIOD_W-1:0] PERIOD_RESET    = PERIOD_W'(40);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_INNER_KP       = 3'd0,
        REG_INNER_KI       = 3'd1,
        REG_INNER_KD       = 3'd2,
        REG_OUTER_KP       = 3'd3,
        REG_OUTER_KI       = 3'd4,
        REG_OUTER_KD       = 3'd5,
        REG_CONTROL_PERIOD = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic signed [ERR_W-1:0]         prev_err;
        logic signed [INTEGRAL_BITS-1:0] integ;
    } pid_state_t;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
    } pid_gains_t;

endpackage

`default_nettype wire

// ----- hdl/cpsp_pid.sv -----
// One PID step: error saturation, integrator update and clamped gain sum.
`default_nettype none

module cpsp_pid (
    input  logic signed [cpsp_pkg::ERR_WIDE_W-1:0] err_wide,
    input  cpsp_pkg::pid_state_t                   state,
    input  cpsp_pkg::pid_gains_t                   gains,
    input  logic signed [cpsp_pkg::LIM_W-1:0]      limit,
    output cpsp_pkg::pid_state_t                   state_next,
    output logic signed [cpsp_pkg::LIM_W-1:0]      drive
);

    localparam int EW  = cpsp_pkg::ERR_WIDE_W;
    localparam int E   = cpsp_pkg::ERR_W;
    localparam int IB  = cpsp_pkg::INTEGRAL_BITS;
    localparam int SW  = cpsp_pkg::PID_SUM_W;

    localparam logic signed [EW-1:0] ERR_HI = {{(EW-E+1){1'b0}}, {(E-1){1'b1}}};
    localparam logic signed [EW-1:0] ERR_LO = {{(EW-E+1){1'b1}}, {(E-1){1'b0}}};
    localparam logic signed [IB-1:0] INT_HI = {1'b0, {(IB-1){1'b1}}};
    localparam logic signed [IB-1:0] INT_LO = {1'b1, {(IB-1){1'b0}}};

    logic signed [E-1:0]                      err;
    logic signed [E:0]                        diff;
    logic signed [IB:0]                       isum;
    logic signed [IB-1:0]                     integ_n;
    logic signed [cpsp_pkg::PROD_P_W-1:0]     pprod;
    logic signed [cpsp_pkg::PROD_D_W-1:0]     dprod;
    logic signed [cpsp_pkg::PROD_I_W-1:0]     iprod;
    logic signed [cpsp_pkg::ITERM_W-1:0]      iterm;
    logic signed [SW-1:0]                     total;
    logic signed [SW-1:0]                     lim_w;

    always_comb
    begin
        if (err_wide > ERR_HI)
        begin
            err = ERR_HI[E-1:0];
        end
        else if (err_wide < ERR_LO)
        begin
            err = ERR_LO[E-1:0];
        end
        else
        begin
            err = err_wide[E-1:0];
        end
    end

    assign diff = (E+1)'(err) - (E+1)'(state.prev_err);

    // Saturate the integrator at its own width; a zero gain clears it
    always_comb
    begin
        isum = (IB+1)'(state.integ) + (IB+1)'(err);
        if (gains.ki == '0)
        begin
            integ_n = '0;
        end
        else if (isum[IB] != isum[IB-1])
        begin
            integ_n = isum[IB] ? INT_LO : INT_HI;
        end
        else
        begin
            integ_n = isum[IB-1:0];
        end
    end

    assign pprod = $signed({1'b0, gains.kp}) * err;
    assign dprod = $signed({1'b0, gains.kd}) * diff;
    assign iprod = $signed({1'b0, gains.ki}) * integ_n;

    generate
        if (cpsp_pkg::PROD_I_W > cpsp_pkg::TERM_SHIFT + 1)
        begin : g_term_sat
            localparam logic signed [cpsp_pkg::PROD_I_W-1:0] TERM_HI =
                cpsp_pkg::PROD_I_W'(1) << cpsp_pkg::TERM_SHIFT;
            always_comb
            begin
                if (iprod > TERM_HI)
                begin
                    iterm = cpsp_pkg::ITERM_W'(TERM_HI);
                end
                else if (iprod < -TERM_HI)
                begin
                    iterm = cpsp_pkg::ITERM_W'(-TERM_HI);
                end
                else
                begin
                    iterm = cpsp_pkg::ITERM_W'(iprod);
                end
            end
        end
        else
        begin : g_term_full
            assign iterm = iprod;
        end
    endgenerate

    assign total = SW'(pprod) + SW'(dprod) + SW'(iterm);
    assign lim_w = SW'(limit);

    always_comb
    begin
        if (total > lim_w)
        begin
            drive = limit;
        end
        else if (total < -lim_w)
        begin
            drive = -limit;
        end
        else
        begin
            drive = cpsp_pkg::LIM_W'(total);
        end
    end

    assign state_next.prev_err = err;
    assign state_next.integ    = integ_n;

endmodule

`default_nettype wire

// ----- hdl/cascaded_position_speed_pid.sv -----
// Top level of the cascaded position/speed PID controller.
// Takes one tick request per cycle: encoder counts of the tick and the position
// target. Counts are summed until the tick count passes control_period; that
// control tick adds the sum to the 16-bit position, runs the speed loop on the
// speed target held from the previous control tick (motor drive, +-100), then
// the position loop (new speed target, +-20 in Q.12) and issues one result.
// Other ticks issue nothing. An accepted tick is held in the input register, and
// when it advances its result is loaded into the result register, which drives
// out_valid. Throughput is one tick per cycle, as both PID units are combinational;
// the input stage holds only when a control tick meets a result that has not yet
// been taken. Configuration writes are always ready and must be made while idle.
`default_nettype none

module cascaded_position_speed_pid (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [cpsp_pkg::DELTA_W-1:0]    encoder_delta,
    input  logic signed [cpsp_pkg::COUNT_W-1:0]    position_target,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [cpsp_pkg::MOTOR_W-1:0]    motor_drive,
    output logic signed [cpsp_pkg::SPEED_TGT_W-1:0] speed_target,
    output logic signed [cpsp_pkg::COUNT_W-1:0]    position,
    output logic signed [cpsp_pkg::COUNT_W-1:0]    speed,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [cpsp_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [cpsp_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int F   = cpsp_pkg::FRACTION_BITS;
    localparam int EW  = cpsp_pkg::ERR_WIDE_W;
    localparam int LW  = cpsp_pkg::LIM_W;
    localparam int HW  = cpsp_pkg::HELD_W;
    localparam int CW  = cpsp_pkg::COUNT_W;
    localparam int PW  = cpsp_pkg::PERIOD_W;

    localparam logic signed [LW:0] MOTOR_BIAS = (LW+1)'((1 << cpsp_pkg::SUM_FRAC) - 1);
    localparam logic signed [LW:0] HELD_BIAS  = (LW+1)'((1 << cpsp_pkg::GAIN_FRAC) - 1);

    // Configuration
    cpsp_pkg::pid_gains_t   inner_gains_reg;
    cpsp_pkg::pid_gains_t   outer_gains_reg;
    logic [PW-1:0]          period_reg;

    // Input stage
    logic                                 in_valid_reg;
    logic signed [cpsp_pkg::DELTA_W-1:0]  delta_reg;
    logic signed [CW-1:0]                 target_reg;

    // Loop state
    logic [PW-1:0]          tick_count_reg;
    logic [CW-1:0]          speed_acc_reg;
    logic [CW-1:0]          position_reg;
    logic signed [HW-1:0]   held_reg;
    cpsp_pkg::pid_state_t   inner_state_reg;
    cpsp_pkg::pid_state_t   outer_state_reg;

    // Result register
    logic                                    out_valid_reg;
    logic signed [cpsp_pkg::MOTOR_W-1:0]     motor_reg;
    logic signed [cpsp_pkg::SPEED_TGT_W-1:0] speed_target_reg;
    logic signed [CW-1:0]                    position_out_reg;
    logic signed [CW-1:0]                    speed_out_reg;

    logic                   in_load;
    logic                   advance;
    logic                   is_ctrl;
    logic                   res_load;
    logic [PW:0]            tick_next;
    logic [CW-1:0]          acc_next;
    logic [CW-1:0]          position_next;
    logic signed [EW-1:0]   inner_err;
    logic signed [EW-1:0]   outer_err;
    cpsp_pkg::pid_state_t   inner_state_next;
    cpsp_pkg::pid_state_t   outer_state_next;
    logic signed [LW-1:0]   inner_drive;
    logic signed [LW-1:0]   outer_drive;
    logic signed [LW:0]     motor_wide;
    logic signed [LW:0]     held_wide;
    logic signed [HW-1:0]   held_next;
    logic signed [cpsp_pkg::MOTOR_W-1:0] motor_next;

    // Handshake
    assign tick_next = {1'b0, tick_count_reg} + (PW+1)'(1);
    assign is_ctrl   = tick_next > {1'b0, period_reg};
    assign advance   = in_valid_reg && (!is_ctrl || !out_valid_reg || out_ready);
    assign res_load  = advance && is_ctrl;
    assign in_ready  = !in_valid_reg || advance;
    assign in_load   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Datapath of one tick
    assign acc_next      = speed_acc_reg + CW'(delta_reg);
    assign position_next = position_reg + acc_next;

    assign inner_err = EW'(held_reg) - (EW'($signed(acc_next)) <<< F);
    assign outer_err = (EW'(target_reg) - EW'($signed(position_next))) <<< F;

    cpsp_pid u_inner (
        .err_wide   (inner_err),
        .state      (inner_state_reg),
        .gains      (inner_gains_reg),
        .limit      (cpsp_pkg::INNER_LIMIT),
        .state_next (inner_state_next),
        .drive      (inner_drive)
    );

    cpsp_pid u_outer (
        .err_wide   (outer_err),
        .state      (outer_state_reg),
        .gains      (outer_gains_reg),
        .limit      (cpsp_pkg::OUTER_LIMIT),
        .state_next (outer_state_next),
        .drive      (outer_drive)
    );

    // Scale down with truncation toward zero
    always_comb
    begin
        motor_wide = (LW+1)'(inner_drive) + (inner_drive[LW-1] ? MOTOR_BIAS : '0);
        held_wide  = (LW+1)'(outer_drive) + (outer_drive[LW-1] ? HELD_BIAS : '0);
        motor_next = cpsp_pkg::MOTOR_W'(motor_wide >>> cpsp_pkg::SUM_FRAC);
        held_next  = HW'(held_wide >>> cpsp_pkg::GAIN_FRAC);
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_gains_reg.kp <= cpsp_pkg::INNER_KP_RESET;
            inner_gains_reg.ki <= cpsp_pkg::INNER_KI_RESET;
            inner_gains_reg.kd <= cpsp_pkg::INNER_KD_RESET;
            outer_gains_reg.kp <= cpsp_pkg::OUTER_KP_RESET;
            outer_gains_reg.ki <= cpsp_pkg::OUTER_KI_RESET;
            outer_gains_reg.kd <= cpsp_pkg::OUTER_KD_RESET;
            period_reg         <= cpsp_pkg::PERIOD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cpsp_pkg::cfg_reg_t'(cfg_index))
                cpsp_pkg::REG_INNER_KP:       inner_gains_reg.kp <= cfg_data;
                cpsp_pkg::REG_INNER_KI:       inner_gains_reg.ki <= cfg_data;
                cpsp_pkg::REG_INNER_KD:       inner_gains_reg.kd <= cfg_data;
                cpsp_pkg::REG_OUTER_KP:       outer_gains_reg.kp <= cfg_data;
                cpsp_pkg::REG_OUTER_KI:       outer_gains_reg.ki <= cfg_data;
                cpsp_pkg::REG_OUTER_KD:       outer_gains_reg.kd <= cfg_data;
                cpsp_pkg::REG_CONTROL_PERIOD: period_reg <= cfg_data[PW-1:0];
                default:                      ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_load)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            delta_reg  <= encoder_delta;
            target_reg <= position_target;
        end
    end

    // Loop state: accumulate on ordinary ticks, run both loops on a control tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg  <= '0;
            speed_acc_reg   <= '0;
            position_reg    <= '0;
            held_reg        <= '0;
            inner_state_reg <= '0;
            outer_state_reg <= '0;
        end
        else if (advance)
        begin
            if (is_ctrl)
            begin
                tick_count_reg  <= '0;
                speed_acc_reg   <= '0;
                position_reg    <= position_next;
                held_reg        <= held_next;
                inner_state_reg <= inner_state_next;
                outer_state_reg <= outer_state_next;
            end
            else
            begin
                tick_count_reg <= tick_next[PW-1:0];
                speed_acc_reg  <= acc_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            motor_reg        <= motor_next;
            speed_target_reg <= cpsp_pkg::SPEED_TGT_W'(held_next);
            position_out_reg <= $signed(position_next);
            speed_out_reg    <= $signed(acc_next);
        end
    end

    assign out_valid    = out_valid_reg;
    assign motor_drive  = motor_reg;
    assign speed_target = speed_target_reg;
    assign position     = position_out_reg;
    assign speed        = speed_out_reg;

`ifndef ASSERT_OFF
    a_ctrl_restarts_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> (tick_count_reg == '0 && speed_acc_reg == '0))
        else $error("control tick did not restart the tick count");

    a_motor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (motor_reg <= cpsp_pkg::DRIVE_LIMIT &&
                           motor_reg >= -cpsp_pkg::DRIVE_LIMIT))
        else $error("motor drive outside its limit");

    a_blocked_tick_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && is_ctrl && out_valid_reg && !out_ready)
            |=> (in_valid_reg && $stable(delta_reg) && $stable(target_reg)))
        else $error("control tick lost while result stalled");

    a_zero_ki_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && inner_gains_reg.ki == '0 && outer_gains_reg.ki == '0)
            |=> (inner_state_reg.integ == '0 && outer_state_reg.integ == '0))
        else $error("integrator not cleared with zero integral gain");
`endif

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the cascaded position/speed PID controller.
`timescale 1ns / 1ps

module tb_top;

    import cpsp_pkg::*;

    localparam int     CLK_HALF        = 4;
    localparam int     RESET_CYCLES    = 11;
    localparam int     SETTLE_CYCLES   = 4;
    localparam int     DRAIN_LIMIT     = 5000;
    localparam int     HOLD_OFF_CYCLES = 100;
    localparam int     REPORT_LIMIT    = 40;
    localparam int     RANDOM_ROUNDS   = 6;
    localparam int     ROUND_TICKS     = 55;
    localparam longint ERR_MAX         = 64'sd2147483647;
    localparam longint ERR_MIN         = -64'sd2147483648;
    localparam longint ONE             = longint'(1) << FRACTION_BITS;
    localparam longint WIDE            = longint'(1) << SUM_FRAC;

    // Index outside the register map; the block must ignore it
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum {DELTA_FULL, DELTA_DRIFT, DELTA_SMALL} delta_mode_t;

    typedef struct {
        logic signed [MOTOR_W-1:0]     motor;
        logic signed [SPEED_TGT_W-1:0] target;
        logic signed [COUNT_W-1:0]     pos;
        logic signed [COUNT_W-1:0]     spd;
    } drive_result_t;

    typedef struct {
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  data;
    } reg_write_t;

    logic                          clk             = 1'b0;
    logic                          rst_n           = 1'b0;
    logic                          in_valid        = 1'b0;
    logic                          in_ready;
    logic signed [DELTA_W-1:0]     encoder_delta   = '0;
    logic signed [COUNT_W-1:0]     position_target = '0;
    logic                          out_valid;
    logic                          out_ready       = 1'b0;
    logic signed [MOTOR_W-1:0]     motor_drive;
    logic signed [SPEED_TGT_W-1:0] speed_target;
    logic signed [COUNT_W-1:0]     position;
    logic signed [COUNT_W-1:0]     speed;
    logic                          cfg_valid       = 1'b0;
    logic                          cfg_ready;
    logic [CFG_INDEX_W-1:0]        cfg_index       = '0;
    logic [CFG_DATA_W-1:0]         cfg_data        = '0;

    // Controller copy: settings and state
    pid_gains_t          speed_gains  = '{kp: INNER_KP_RESET, ki: INNER_KI_RESET,
                                          kd: INNER_KD_RESET};
    pid_gains_t          pos_gains    = '{kp: OUTER_KP_RESET, ki: OUTER_KI_RESET,
                                          kd: OUTER_KD_RESET};
    logic [PERIOD_W-1:0] period_cfg   = PERIOD_RESET;
    int                  tick_count   = 0;
    logic [COUNT_W-1:0]  spd_accum    = '0;
    logic [COUNT_W-1:0]  pos_count    = '0;
    longint              held_target  = 0;
    longint              speed_prev   = 0;
    longint              speed_integ  = 0;
    longint              pos_prev     = 0;
    longint              pos_integ    = 0;

    drive_result_t pending_drives[$];
    reg_write_t    reg_writes[$];

    int errors         = 0;
    int ticks_sent     = 0;
    int results_seen   = 0;
    int writes_done    = 0;
    int input_stalls   = 0;
    bit sender_gaps    = 1'b1;
    bit hold_off_req   = 1'b0;
    bit hold_off_busy  = 1'b0;

    cascaded_position_speed_pid uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .encoder_delta   (encoder_delta),
        .position_target (position_target),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .motor_drive     (motor_drive),
        .speed_target    (speed_target),
        .position        (position),
        .speed           (speed),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // One PID pass; returns the clamped sum in Q.(F+12)
    function automatic longint pid_update(input longint err_wide, inout longint prev,
                                          inout longint integ, input pid_gains_t g,
                                          input longint lim);
        longint e;
        longint d;
        longint i;
        longint imax;
        longint sum;
        e = err_wide;
        if (e > ERR_MAX)
            e = ERR_MAX;
        else if (e < ERR_MIN)
            e = ERR_MIN;
        d = e - prev;
        prev = e;
        imax = (longint'(1) << (INTEGRAL_BITS - 1)) - 1;
        if (g.ki == '0)
            i = 0;
        else
        begin
            i = integ + e;
            if (i > imax)
                i = imax;
            else if (i < -imax - 1)
                i = -imax - 1;
        end
        integ = i;
        // at these widths the I product stays far below its 2^62 ceiling
        sum = longint'(g.kp) * e + longint'(g.kd) * d + longint'(g.ki) * i;
        if (sum > lim)
            sum = lim;
        else if (sum < -lim)
            sum = -lim;
        return sum;
    endfunction

    function automatic void step_controller(input logic signed [DELTA_W-1:0] delta,
                                            input logic signed [COUNT_W-1:0] target,
                                            output bit fired, output drive_result_t res);
        logic [COUNT_W-1:0] acc;
        int                 count_next;
        longint             spd;
        longint             pos;
        longint             s_in;
        longint             s_out;
        acc = spd_accum + COUNT_W'(delta);
        count_next = tick_count + 1;
        fired = 1'b0;
        res = '{default: '0};
        if (count_next <= int'(period_cfg))
        begin
            tick_count = count_next;
            spd_accum = acc;
            return;
        end
        fired = 1'b1;
        tick_count = 0;
        spd_accum = '0;
        pos_count = pos_count + acc;
        spd = longint'($signed(acc));
        pos = longint'($signed(pos_count));
        // speed loop runs on the target held from the previous control tick
        s_in = pid_update(held_target - spd * ONE, speed_prev, speed_integ, speed_gains,
                          longint'(DRIVE_LIMIT) * WIDE);
        s_out = pid_update((longint'(target) - pos) * ONE, pos_prev, pos_integ, pos_gains,
                           longint'(TARGET_LIMIT) * WIDE);
        held_target = s_out / (longint'(1) << GAIN_FRAC);
        res.motor  = MOTOR_W'(s_in / WIDE);
        res.target = SPEED_TGT_W'(held_target);
        res.pos    = pos_count;
        res.spd    = acc;
    endfunction

    function automatic logic [GAIN_W-1:0] random_gain();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 16)
            return '1;
        if (r < 80)
            return GAIN_W'($urandom_range(0, 8191));
        return GAIN_W'($urandom);
    endfunction

    // Register write channel: drain the queue one request at a time
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (rst_n && cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_INNER_KP:       speed_gains.kp = cfg_data;
                    REG_INNER_KI:       speed_gains.ki = cfg_data;
                    REG_INNER_KD:       speed_gains.kd = cfg_data;
                    REG_OUTER_KP:       pos_gains.kp = cfg_data;
                    REG_OUTER_KI:       pos_gains.ki = cfg_data;
                    REG_OUTER_KD:       pos_gains.kd = cfg_data;
                    REG_CONTROL_PERIOD: period_cfg = cfg_data[PERIOD_W-1:0];
                    default: ;
                endcase
                void'(reg_writes.pop_front());
                writes_done++;
            end
            if (reg_writes.size() != 0)
            begin
                cfg_valid <= 1'b1;
                cfg_index <= reg_writes[0].idx;
                cfg_data  <= reg_writes[0].data;
            end
            else
                cfg_valid <= 1'b0;
            @(posedge clk);
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        int r;
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_off_busy = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_busy = 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                begin
                    out_ready <= 1'b1;
                    repeat ($urandom_range(1, 40)) @(posedge clk);
                end
                else if (r < 92)
                begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                end
                else
                begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(8, 40)) @(posedge clk);
                end
            end
        end
    end

    task automatic note_mismatch(input string field, input longint want, input longint got);
        errors++;
        if (errors <= REPORT_LIMIT)
            $error("%s: expected %0d, got %0d", field, want, got);
    endtask

    always @(posedge clk)
    begin : result_check
        drive_result_t want;
        if (rst_n && in_valid && !in_ready)
            input_stalls++;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_drives.size() == 0)
            begin
                errors++;
                $error("result with no control tick outstanding");
            end
            else
            begin
                want = pending_drives.pop_front();
                results_seen++;
                if (motor_drive !== want.motor)
                    note_mismatch("motor_drive", longint'(want.motor),
                                  longint'(motor_drive));
                if (speed_target !== want.target)
                    note_mismatch("speed_target", longint'(want.target),
                                  longint'(speed_target));
                if (position !== want.pos)
                    note_mismatch("position", longint'(want.pos), longint'(position));
                if (speed !== want.spd)
                    note_mismatch("speed", longint'(want.spd), longint'(speed));
            end
        end
    end

    task automatic send_tick(input logic signed [DELTA_W-1:0] delta,
                             input logic signed [COUNT_W-1:0] target);
        int            r;
        int            gap;
        bit            fired;
        drive_result_t res;
        gap = 0;
        if (sender_gaps)
        begin
            r = $urandom_range(0, 99);
            if (r >= 92)
                gap = $urandom_range(8, 30);
            else if (r >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        encoder_delta   <= delta;
        position_target <= target;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        ticks_sent++;
        step_controller(delta, target, fired, res);
        if (fired)
            pending_drives.push_back(res);
    endtask

    // Drop valid and let every outstanding result drain before touching registers
    task automatic wait_quiet();
        int n;
        n = 0;
        in_valid <= 1'b0;
        while (pending_drives.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        if (pending_drives.size() != 0)
        begin
            errors++;
            $error("%0d expected results never arrived", pending_drives.size());
            pending_drives.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        reg_writes.push_back('{idx: idx, data: data});
        while (reg_writes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_all_gains(input logic [GAIN_W-1:0] g);
        write_reg(REG_INNER_KP, g);
        write_reg(REG_INNER_KI, g);
        write_reg(REG_INNER_KD, g);
        write_reg(REG_OUTER_KP, g);
        write_reg(REG_OUTER_KI, g);
        write_reg(REG_OUTER_KD, g);
    endtask

    // Lower the period under a running count, then poke an unmapped index
    task automatic test_period_change();
        repeat (5) send_tick(DELTA_W'($urandom), COUNT_W'($urandom));
        wait_quiet();
        write_reg(REG_CONTROL_PERIOD, 16'd2);
        send_tick(DELTA_W'($urandom), COUNT_W'($urandom));
        repeat (3) send_tick(DELTA_W'($urandom), COUNT_W'($urandom));
        wait_quiet();
        write_reg(REG_UNUSED, 16'hFFFF);
        repeat (3) send_tick(DELTA_W'($urandom), COUNT_W'($urandom));
    endtask

    task automatic test_field_extremes();
        wait_quiet();
        write_reg(REG_CONTROL_PERIOD, 16'd0);
        send_tick(8'sd127, 16'sd32767);
        send_tick(8'h80, 16'h8000);
        send_tick(8'sd0, 16'sd0);
        send_tick(8'hFF, 16'hFFFF);
        send_tick(8'h55, 16'h5555);
        send_tick(8'hAA, 16'hAAAA);
    endtask

    task automatic test_zero_integral_gain();
        wait_quiet();
        write_reg(REG_OUTER_KI, 16'd2048);
        repeat (2) send_tick(DELTA_W'($urandom), COUNT_W'($urandom));
        wait_quiet();
        // both integrators hold something now; a zero gain must clear them
        write_reg(REG_INNER_KI, 16'd0);
        write_reg(REG_OUTER_KI, 16'd0);
        write_reg(REG_CONTROL_PERIOD, 16'd1);
        repeat (4) send_tick(DELTA_W'($urandom), COUNT_W'($urandom));
    endtask

    task automatic test_gain_extremes();
        wait_quiet();
        write_all_gains('1);
        write_reg(REG_CONTROL_PERIOD, 16'd0);
        send_tick(8'sd127, 16'h8000);
        send_tick(8'h80, 16'sd32767);
        wait_quiet();
        write_all_gains('0);
        send_tick(8'sd5, 16'sd100);
        send_tick(-8'sd5, -16'sd100);
    endtask

    task automatic test_random_settings();
        delta_mode_t        mode;
        logic signed [COUNT_W-1:0] aim;
        logic signed [DELTA_W-1:0] delta;
        bit                 upward;
        int                 m;
        for (int round = 0; round < RANDOM_ROUNDS; round++)
        begin
            wait_quiet();
            write_reg(REG_INNER_KP, random_gain());
            write_reg(REG_INNER_KI, random_gain());
            write_reg(REG_INNER_KD, random_gain());
            write_reg(REG_OUTER_KP, random_gain());
            write_reg(REG_OUTER_KI, random_gain());
            write_reg(REG_OUTER_KD, random_gain());
            if ($urandom_range(0, 99) < 85)
                write_reg(REG_CONTROL_PERIOD, CFG_DATA_W'($urandom_range(0, 7)));
            else
                write_reg(REG_CONTROL_PERIOD, CFG_DATA_W'($urandom_range(8, 40)));
            sender_gaps = ($urandom_range(0, 4) != 0);
            mode = delta_mode_t'($urandom_range(0, 2));
            upward = 1'($urandom_range(0, 1));
            aim = COUNT_W'($urandom);
            for (int k = 0; k < ROUND_TICKS; k++)
            begin
                case (mode)
                    DELTA_FULL:  delta = DELTA_W'($urandom);
                    DELTA_DRIFT:
                    begin
                        m = $urandom_range(64, 128);
                        delta = upward ? DELTA_W'(m - 1) : DELTA_W'(-m);
                    end
                    default:     delta = DELTA_W'($urandom_range(0, 6) - 3);
                endcase
                // mostly track a fixed target, now and then jump anywhere
                if ($urandom_range(0, 9) == 0)
                    send_tick(delta, COUNT_W'($urandom));
                else
                    send_tick(delta, aim);
            end
        end
        sender_gaps = 1'b1;
    endtask

    // Longest period, speed at its extreme, position carried across the wrap
    task automatic test_long_period();
        logic signed [DELTA_W-1:0] push;
        wait_quiet();
        write_reg(REG_CONTROL_PERIOD, 16'd0);
        // a full run of +127 from this band would stop just short of the wrap
        while ($signed(pos_count) >= 0 && $signed(pos_count) <= 255)
            send_tick(8'sd127, COUNT_W'($urandom));
        wait_quiet();
        write_reg(REG_CONTROL_PERIOD, 16'd255);
        push = ($signed(pos_count) < 0) ? 8'h80 : 8'h7F;
        repeat (256) send_tick(push, COUNT_W'($urandom));
    endtask

    // Hold results off long enough for the input side to back up
    task automatic test_output_backpressure();
        wait_quiet();
        write_reg(REG_CONTROL_PERIOD, 16'd0);
        sender_gaps = 1'b0;
        hold_off_req = 1'b1;
        while (!hold_off_busy)
            @(posedge clk);
        repeat (40) send_tick(DELTA_W'($urandom), COUNT_W'($urandom));
        sender_gaps = 1'b1;
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_period_change();
        test_field_extremes();
        test_zero_integral_gain();
        test_gain_extremes();
        test_random_settings();
        test_long_period();
        test_output_backpressure();
        wait_quiet();
        $display("Checked %0d control results from %0d ticks across %0d register writes.",
                 results_seen, ticks_sent, writes_done);
        $display("Input side was held off for %0d cycles while results backed up.",
                 input_stalls);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/cpsp_pkg.sv
hdl/cpsp_pid.sv
hdl/cascaded_position_speed_pid.sv
dv/tb_top.sv
